@@ rtl/uud_pkg.sv @@
package uud_pkg;

    // Decoder line state
    typedef enum logic [1:0] {
        MODE_LEN  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_SKIP = 2'd2,
        MODE_DONE = 2'd3
    } t_mode;

    // One unit of output work: emit cnt bytes, the first three taken from grp
    // (oldest byte highest) and the rest zero; clr clears the byte total after.
    typedef struct packed {
        logic [23:0] grp;
        logic [5:0]  cnt;
        logic        clr;
    } t_job;

    localparam logic [7:0]  CHAR_BIAS  = 8'd32;
    localparam logic [5:0]  DIGIT_MASK = 6'h3f;
    localparam logic [7:0]  CHAR_LF    = 8'h0a;
    localparam logic [7:0]  CHAR_CR    = 8'h0d;
    localparam logic [31:0] TOTAL_MAX  = 32'hffff_ffff;

endpackage

@@ rtl/uud_if.sv @@
interface uud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface uud_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic [31:0] total_written;

    modport source (output valid, output out_byte, output run_last, output total_written,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input total_written,
                    output ready);
endinterface

@@ rtl/uud_front.sv @@
module uud_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uud_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output uud_pkg::t_job o_job
);
    import uud_pkg::*;

    t_mode       r_mode, n_mode;
    logic [5:0]  r_rem, n_rem;
    logic [1:0]  r_gp, n_gp;
    logic [17:0] r_held, n_held;

    logic        accept;
    logic        is_lf, is_cr;
    logic [7:0]  biased;
    logic [5:0]  digit;
    logic [23:0] grp_v;
    logic [5:0]  grp_cnt;
    logic [5:0]  take3;

    // Left-justify the held digits in a 24-bit group, zero digits padding the tail.
    function automatic logic [23:0] pad_group(input logic [17:0] held, input logic [1:0] gp);
        logic [23:0] v;
        case (gp)
            2'd0:    v = 24'd0;
            2'd1:    v = {held[5:0], 18'd0};
            2'd2:    v = {held[11:0], 12'd0};
            2'd3:    v = {held, 6'd0};
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign is_lf      = (i_in.in_byte == CHAR_LF);
    assign is_cr      = (i_in.in_byte == CHAR_CR);
    assign biased     = i_in.in_byte - CHAR_BIAS;
    assign digit      = biased[5:0] & DIGIT_MASK;
    assign take3      = (r_rem < 6'd3) ? r_rem : 6'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LEN;
            r_rem  <= '0;
            r_gp   <= '0;
            r_held <= '0;
        end else begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_gp   <= n_gp;
            r_held <= n_held;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_rem   = r_rem;
        n_gp    = r_gp;
        n_held  = r_held;
        grp_v   = '0;
        grp_cnt = '0;
        o_push  = 1'b0;
        o_job   = '0;

        if (accept) begin
            case (r_mode)
                MODE_LEN: begin
                    if (!is_lf && !is_cr) begin
                        if (digit == 6'd0) begin
                            n_mode = MODE_DONE;
                        end else begin
                            n_rem  = digit;
                            n_gp   = 2'd0;
                            n_held = '0;
                            n_mode = MODE_DATA;
                        end
                    end
                end
                MODE_DATA: begin
                    if (is_lf || is_cr) begin
                        // early line end: flush everything still owed
                        grp_v   = pad_group(r_held, r_gp);
                        grp_cnt = r_rem;
                        n_rem   = '0;
                        n_gp    = 2'd0;
                        n_held  = '0;
                        n_mode  = is_lf ? MODE_LEN : MODE_SKIP;
                    end else if (r_gp == 2'd3) begin
                        grp_v   = {r_held, digit};
                        grp_cnt = take3;
                        n_rem   = r_rem - take3;
                        n_gp    = 2'd0;
                        n_held  = '0;
                        if (r_rem == take3) begin
                            n_mode = MODE_SKIP;
                        end
                    end else begin
                        n_held = {r_held[11:0], digit};
                        n_gp   = r_gp + 2'd1;
                    end
                end
                MODE_SKIP: begin
                    if (is_lf) begin
                        n_mode = MODE_LEN;
                    end
                end
                default: begin
                end
            endcase

            o_job.grp = grp_v;
            o_job.cnt = grp_cnt;
            o_push    = (grp_cnt != 6'd0);

            if (i_in.end_of_buffer) begin
                // flush the open line into the same job, then drop back to reset
                if (n_mode == MODE_DATA) begin
                    o_job.cnt = grp_cnt + n_rem;
                    if (grp_cnt == 6'd0) begin
                        o_job.grp = pad_group(n_held, n_gp);
                    end
                end
                o_job.clr = 1'b1;
                o_push    = 1'b1;
                n_mode    = MODE_LEN;
                n_rem     = '0;
                n_gp      = 2'd0;
                n_held    = '0;
            end
        end
    end

endmodule

@@ rtl/uud_queue.sv @@
module uud_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uud_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output uud_pkg::t_job o_job
);
    import uud_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/uud_back.sv @@
module uud_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  uud_pkg::t_job i_job,
    output logic          o_pop,
    uud_out_if.source     o_out
);
    import uud_pkg::*;

    t_job        r_job;
    logic        r_active;
    logic [5:0]  r_idx;
    logic [31:0] r_total;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic [31:0] r_ototal;

    logic        adv;
    logic        last;
    logic [7:0]  cur_byte;
    logic [31:0] inc_total;

    assign adv       = r_active && (!r_ovalid || o_out.ready);
    assign last      = (r_idx == (r_job.cnt - 6'd1));
    assign o_pop     = i_job_valid && (!r_active || (adv && last));
    assign inc_total = (r_total == TOTAL_MAX) ? r_total : r_total + 32'd1;

    always_comb begin
        case (r_idx)
            6'd0:    cur_byte = r_job.grp[23:16];
            6'd1:    cur_byte = r_job.grp[15:8];
            6'd2:    cur_byte = r_job.grp[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_byte      = r_obyte;
    assign o_out.run_last      = r_olast;
    assign o_out.total_written = r_ototal;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte  <= cur_byte;
            r_olast  <= last;
            r_ototal <= inc_total;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
                r_idx    <= r_idx + 6'd1;
                r_total  <= (last && r_job.clr) ? 32'd0 : inc_total;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            if (o_pop) begin
                r_idx <= '0;
                if (i_job.cnt == 6'd0) begin
                    // end-of-buffer with nothing owed: just clear the total
                    r_active <= 1'b0;
                    if (i_job.clr) begin
                        r_total <= '0;
                    end
                end else begin
                    r_active <= 1'b1;
                end
            end else if (adv && last) begin
                r_active <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/uudecode_stream.sv @@
// Streaming uudecoder for a body without begin or end lines. The front end
// takes one encoded character per cycle whenever the job queue has room,
// tracks line length, digit grouping and skip state, and turns every finished
// group, early line end or end-of-buffer flush into one job. The back end
// drains jobs from a QUEUE_DEPTH-entry queue and sends one decoded byte per
// cycle while the receiver is ready, through a registered output; a full
// group of four input characters yields up to three output bytes. Input
// stalls only while the queue is full, which happens when a long early-line
// flush (up to 63 zero-padded bytes) is still draining or when the receiver
// holds off the output. The last byte caused by one input character
// carries run_last, and total_written counts bytes since reset or since the
// last end-of-buffer character, saturating at all ones. No clearing pass is
// needed after reset.
module uudecode_stream #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uud_in_if.sink    i_in,
    uud_out_if.source o_out
);
    import uud_pkg::*;

    logic push, full, pop, job_valid;
    t_job push_job, pop_job;

    // Classify characters and build jobs
    uud_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Decouple the two sides so each may stall on its own
    uud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (pop_job)
    );

    // Emit decoded bytes, one transfer per cycle while the receiver is ready
    uud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
